// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; all are clocked on clk and held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/tdq_pkg.sv =====
package tdq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_DROP    = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;

  localparam logic [15:0] TICK_INTERVAL_RST = 16'd1;

  typedef struct packed {
    logic [15:0] remaining;
    logic [7:0]  src_peer;
    logic [7:0]  dst_peer;
    logic [3:0]  msg_type;
    logic [31:0] content_tag;
  } tdq_entry_t;

endpackage

// ===== hdl/tdq_if.sv =====
interface tdq_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  in_src_peer;
  logic [7:0]  in_dst_peer;
  logic [3:0]  in_msg_type;
  logic [15:0] in_delay;
  logic [31:0] in_content_tag;

  modport source (output valid, operation, in_src_peer, in_dst_peer, in_msg_type,
                  in_delay, in_content_tag, input ready);
  modport sink (input valid, operation, in_src_peer, in_dst_peer, in_msg_type,
                in_delay, in_content_tag, output ready);
endinterface

interface tdq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  out_src_peer;
  logic [7:0]  out_dst_peer;
  logic [3:0]  out_msg_type;
  logic [31:0] out_content_tag;
  logic        last_of_run;

  modport source (output valid, result_kind, out_src_peer, out_dst_peer, out_msg_type,
                  out_content_tag, last_of_run, input ready);
  modport sink (input valid, result_kind, out_src_peer, out_dst_peer, out_msg_type,
                out_content_tag, last_of_run, output ready);
endinterface

// ===== hdl/tdq_store.sv =====
module tdq_store
  import tdq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  tdq_entry_t    wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output tdq_entry_t    rdata
);

  tdq_entry_t mem [CAPACITY];
  tdq_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/timed_delivery_queue_core.sv =====
// channel   dir  handshake        payload
// in_ch     in   valid/ready      operation, src, dst, type, delay, tag
// out_ch    out  valid/ready      kind, src, dst, type, tag, last_of_run
// cfg       in   cfg_we (no wait) cfg_wdata = tick_interval
//
// Add: handled in idle, status lands in the output register.
// Tick: for each stored entry, a store read, then subtract/compare in the
//   shared unit and compact write; then an end check and the commit.
// Output stalls hold the walk in place; input is taken only when idle with
//   the output register free. Synchronous active-low reset; no clearing pass.
`include "assert_macros.svh"

module timed_delivery_queue_core
  import tdq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  tdq_in_if.sink      in_ch,
  tdq_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EX   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] interval_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] act_r, act_nxt;   // entries below this are active
  logic [CW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [NW-1:0] n_r, n_nxt;

  logic       hv_r, hv_nxt;
  tdq_entry_t held_r, held_nxt;

  logic        out_v_r, out_v_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  osrc_r, osrc_nxt;
  logic [7:0]  odst_r, odst_nxt;
  logic [3:0]  otype_r, otype_nxt;
  logic [31:0] otag_r, otag_nxt;
  logic        last_r, last_nxt;

  logic        out_free;
  logic        in_xfer;
  logic        st_we, st_re;
  logic [IW-1:0] st_waddr;
  tdq_entry_t  st_wdata, st_rdata;

  logic [16:0] diff;
  logic        is_active, due;

  tdq_store #(.CAPACITY(CAPACITY)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (rd_r[IW-1:0]),
    .rdata (st_rdata)
  );

  assign out_free    = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // shared subtract/compare unit
  assign diff      = {1'b0, st_rdata.remaining} - {1'b0, interval_r};
  assign due       = diff[16] || (diff == 17'd0);
  assign is_active = rd_r < act_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    n_nxt     = n_r;
    hv_nxt    = hv_r;
    held_nxt  = held_r;
    out_v_nxt = out_v_r && !out_ch.ready;
    kind_nxt  = kind_r;
    osrc_nxt  = osrc_r;
    odst_nxt  = odst_r;
    otype_nxt = otype_r;
    otag_nxt  = otag_r;
    last_nxt  = last_r;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_waddr  = wr_r[IW-1:0];
    st_wdata  = st_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.operation == OP_ADD) begin
            out_v_nxt = 1'b1;
            osrc_nxt  = 8'd0;
            odst_nxt  = 8'd0;
            otype_nxt = 4'd0;
            otag_nxt  = 32'd0;
            last_nxt  = 1'b1;
            if (cnt_r < CW'(CAPACITY)) begin
              kind_nxt             = KIND_ACCEPT;
              st_we                = 1'b1;
              st_waddr             = cnt_r[IW-1:0];
              st_wdata.remaining   = in_ch.in_delay;
              st_wdata.src_peer    = in_ch.in_src_peer;
              st_wdata.dst_peer    = in_ch.in_dst_peer;
              st_wdata.msg_type    = in_ch.in_msg_type;
              st_wdata.content_tag = in_ch.in_content_tag;
              cnt_nxt              = cnt_r + CW'(1);
            end else begin
              kind_nxt = KIND_DROP;
            end
          end else begin
            rd_nxt    = '0;
            wr_nxt    = '0;
            n_nxt     = '0;
            hv_nxt    = 1'b0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (rd_r == cnt_r) begin
          state_nxt = ST_DONE;
        end else begin
          st_re     = 1'b1;
          state_nxt = ST_EX;
        end
      end
      ST_EX: begin
        if (is_active && due && (n_r < NW'(MAX_RESULTS))) begin
          // deliver: previous held result goes out as a non-final one
          if (!hv_r || out_free) begin
            if (hv_r) begin
              out_v_nxt = 1'b1;
              kind_nxt  = KIND_DELIVER;
              osrc_nxt  = held_r.src_peer;
              odst_nxt  = held_r.dst_peer;
              otype_nxt = held_r.msg_type;
              otag_nxt  = held_r.content_tag;
              last_nxt  = 1'b0;
            end
            hv_nxt    = 1'b1;
            held_nxt  = st_rdata;
            n_nxt     = n_r + NW'(1);
            rd_nxt    = rd_r + CW'(1);
            state_nxt = ST_RD;
          end
        end else begin
          st_we = 1'b1;
          if (is_active) begin
            st_wdata.remaining = due ? 16'd0 : diff[15:0];
          end
          wr_nxt    = wr_r + CW'(1);
          rd_nxt    = rd_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (!hv_r || out_free) begin
          if (hv_r) begin
            out_v_nxt = 1'b1;
            kind_nxt  = KIND_DELIVER;
            osrc_nxt  = held_r.src_peer;
            odst_nxt  = held_r.dst_peer;
            otype_nxt = held_r.msg_type;
            otag_nxt  = held_r.content_tag;
            last_nxt  = 1'b1;
          end
          hv_nxt    = 1'b0;
          cnt_nxt   = wr_r;
          act_nxt   = wr_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      interval_r <= TICK_INTERVAL_RST;
      cnt_r      <= '0;
      act_r      <= '0;
      rd_r       <= '0;
      wr_r       <= '0;
      n_r        <= '0;
      hv_r       <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      n_r     <= n_nxt;
      hv_r    <= hv_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    kind_r  <= kind_nxt;
    osrc_r  <= osrc_nxt;
    odst_r  <= odst_nxt;
    otype_r <= otype_nxt;
    otag_r  <= otag_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.result_kind     = kind_r;
  assign out_ch.out_src_peer    = osrc_r;
  assign out_ch.out_dst_peer    = odst_r;
  assign out_ch.out_msg_type    = otype_r;
  assign out_ch.out_content_tag = otag_r;
  assign out_ch.last_of_run     = last_r;

  `TDQ_ASSERT_SAME(a_cnt_bound, 1'b1, (cnt_r <= CW'(CAPACITY)) && (act_r <= cnt_r))
  `TDQ_ASSERT_SAME(a_compact_order, state_r != ST_IDLE, (wr_r <= rd_r) && (rd_r <= cnt_r))
  `TDQ_ASSERT_SAME(a_result_bound, state_r != ST_IDLE,
                   (n_r <= NW'(MAX_RESULTS)) && (CW'(n_r) + wr_r == rd_r))
  `TDQ_ASSERT_NEXT(a_final_push, (state_r == ST_DONE) && hv_r && out_free,
                   out_v_r && last_r && (kind_r == KIND_DELIVER) && (state_r == ST_IDLE))

endmodule

// ===== tb/tdq_result_checker.sv =====
module tdq_result_checker
  import tdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tdq_in_if           in_mon,
  tdq_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          errors,
  output int          outstanding
);

  typedef struct {
    int          left;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [3:0]  mtype;
    logic [31:0] tag;
    bit          pend;
  } slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [3:0]  mtype;
    logic [31:0] tag;
    logic        last;
  } result_t;

  slot_t       slots[DEF_CAPACITY];
  int          held;
  logic [15:0] interval;
  result_t     due_q[$];
  int          err_total = 0;
  int          due_total = 0;

  assign errors      = err_total;
  assign outstanding = due_total;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_total++;
  endtask

  task automatic compare_result();
    result_t want;
    if (due_q.size() == 0) begin
      report($sformatf("result with nothing expected, kind %0d", out_mon.result_kind));
    end else begin
      want = due_q.pop_front();
      if (out_mon.result_kind !== want.kind)
        report($sformatf("result_kind got %0d want %0d", out_mon.result_kind, want.kind));
      if (out_mon.out_src_peer !== want.src)
        report($sformatf("out_src_peer got %0h want %0h", out_mon.out_src_peer, want.src));
      if (out_mon.out_dst_peer !== want.dst)
        report($sformatf("out_dst_peer got %0h want %0h", out_mon.out_dst_peer, want.dst));
      if (out_mon.out_msg_type !== want.mtype)
        report($sformatf("out_msg_type got %0h want %0h", out_mon.out_msg_type, want.mtype));
      if (out_mon.out_content_tag !== want.tag)
        report($sformatf("out_content_tag got %0h want %0h",
                         out_mon.out_content_tag, want.tag));
      if (out_mon.last_of_run !== want.last)
        report($sformatf("last_of_run got %0b want %0b", out_mon.last_of_run, want.last));
    end
  endtask

  task automatic predict_item();
    int      wr;
    int      n;
    int      due_cnt;
    int      v;
    bit      keep;
    slot_t   s;
    result_t r;
    r = '0;
    if (in_mon.operation == OP_ADD) begin
      r.last = 1'b1;
      if (held >= DEF_CAPACITY) begin
        r.kind = KIND_DROP;
      end else begin
        slots[held].left  = int'(in_mon.in_delay);
        slots[held].src   = in_mon.in_src_peer;
        slots[held].dst   = in_mon.in_dst_peer;
        slots[held].mtype = in_mon.in_msg_type;
        slots[held].tag   = in_mon.in_content_tag;
        slots[held].pend  = 1'b1;
        held++;
        r.kind = KIND_ACCEPT;
      end
      due_q = {due_q, r};
    end else begin
      // count deliveries up front so the last one of the walk can be flagged
      due_cnt = 0;
      for (int i = 0; i < held; i++) begin
        if (!slots[i].pend && slots[i].left - int'(interval) <= 0) due_cnt++;
      end
      if (due_cnt > MAX_RESULTS) due_cnt = MAX_RESULTS;
      wr = 0;
      n  = 0;
      for (int rd = 0; rd < held; rd++) begin
        s    = slots[rd];
        keep = 1'b1;
        if (!s.pend) begin
          v = s.left - int'(interval);
          if (v <= 0) begin
            if (n < MAX_RESULTS) begin
              r.kind  = KIND_DELIVER;
              r.src   = s.src;
              r.dst   = s.dst;
              r.mtype = s.mtype;
              r.tag   = s.tag;
              r.last  = (n + 1 == due_cnt);
              due_q   = {due_q, r};
              n++;
              keep = 1'b0;
            end else begin
              v = 0;
            end
          end
          s.left = v;
        end
        if (keep) begin
          slots[wr] = s;
          wr++;
        end
      end
      held = wr;
      for (int i = 0; i < DEF_CAPACITY; i++) slots[i].pend = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held     = 0;
      interval = TICK_INTERVAL_RST;
      due_q.delete();
      for (int i = 0; i < DEF_CAPACITY; i++) slots[i].pend = 1'b0;
      due_total = 0;
    end else begin
      if (cfg_we) interval = cfg_wdata;
      // results first: a transfer out at this edge belongs to an older item
      if (out_mon.valid && out_mon.ready) compare_result();
      if (in_mon.valid && in_mon.ready) predict_item();
      due_total = due_q.size();
    end
  end

endmodule

// ===== tb/timed_delivery_queue_core_test.sv =====
module timed_delivery_queue_core_test;
  import tdq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  // a tick with no deliveries still walks every stored entry
  localparam int SETTLE_CYCLES = 2 * DEF_CAPACITY + 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          errors;
  int          outstanding;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [15:0] cur_interval = TICK_INTERVAL_RST;

  tdq_in_if  in_ch();
  tdq_out_if out_ch();

  timed_delivery_queue_core #(.CAPACITY(DEF_CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tdq_result_checker watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // present one item and hold it until the transfer
  task automatic offer_item(input logic op, input logic [7:0] src, input logic [7:0] dst,
                            input logic [3:0] mtype, input logic [15:0] delay,
                            input logic [31:0] tag);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.in_src_peer    <= src;
    in_ch.in_dst_peer    <= dst;
    in_ch.in_msg_type    <= mtype;
    in_ch.in_delay       <= delay;
    in_ch.in_content_tag <= tag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic add_msg(input logic [7:0] src, input logic [7:0] dst,
                         input logic [3:0] mtype, input logic [15:0] delay,
                         input logic [31:0] tag);
    offer_item(OP_ADD, src, dst, mtype, delay, tag);
  endtask

  // payload is ignored on a tick, so it carries noise
  task automatic tick_once();
    offer_item(OP_TICK, 8'($urandom), 8'($urandom), 4'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_interval(input logic [15:0] v);
    settle();
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    cur_interval = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    longint      span;
    logic [15:0] d;
    if ($urandom_range(0, 99) < 45) begin
      case ($urandom_range(0, 9))
        0: d = 16'd0;
        1: d = 16'hFFFF;
        2, 3: d = 16'($urandom);
        default: begin
          // keep most delays within a few ticks so deliveries happen
          span = longint'(cur_interval) * $urandom_range(0, 5) +
                 $urandom_range(0, cur_interval);
          d = (span > 65535) ? 16'hFFFF : 16'(span);
        end
      endcase
      add_msg(8'($urandom), 8'($urandom), 4'($urandom), d, $urandom);
    end else begin
      tick_once();
    end
  endtask

  initial begin
    logic [15:0] phase_interval[6];
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_ADD;
    in_ch.in_src_peer    = '0;
    in_ch.in_dst_peer    = '0;
    in_ch.in_msg_type    = '0;
    in_ch.in_delay       = '0;
    in_ch.in_content_tag = '0;
    phase_interval[0] = 16'd1;
    phase_interval[1] = 16'hFFFF;
    phase_interval[2] = 16'd0;
    phase_interval[3] = 16'($urandom_range(2, 50));
    phase_interval[4] = 16'($urandom_range(51, 65534));
    phase_interval[5] = 16'($urandom_range(1, 8));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 51;

    // field extremes; both start pending, so the first tick delivers nothing
    add_msg(8'h00, 8'h00, 4'h0, 16'h0000, 32'h0000_0000);
    add_msg(8'hFF, 8'hFF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF);
    tick_once();
    tick_once();
    // fill the store, then one more add is dropped
    for (int i = 0; i < DEF_CAPACITY - 1; i++) begin
      add_msg(8'($urandom), 8'($urandom), 4'(i), (i % 3 == 0) ? 16'd0 : 16'(i), $urandom);
    end
    add_msg(8'hA5, 8'h5A, 4'h9, 16'd3, 32'hDEAD_BEEF);
    tick_once();
    // widest interval drains a full store in one walk
    set_interval(16'hFFFF);
    tick_once();
    tick_once();
    // zero interval: only zero delays come due
    set_interval(16'd0);
    add_msg(8'h12, 8'h34, 4'h5, 16'd0, 32'h1234_5678);
    add_msg(8'h9A, 8'hBC, 4'hD, 16'd5, 32'h8765_4321);
    tick_once();
    tick_once();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 51;
      end else if (phase < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_interval(phase_interval[phase]);
      for (int k = 0; k < 49; k++) begin
        if ($urandom_range(0, 59) == 0) settle();
        random_item();
      end
    end

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== timed_delivery_queue_core.f =====
+incdir+hdl
hdl/tdq_pkg.sv
hdl/tdq_if.sv
hdl/tdq_store.sv
hdl/timed_delivery_queue_core.sv
tb/tdq_result_checker.sv
tb/timed_delivery_queue_core_test.sv
